// ===== hw/rtl/tfn_pkg.sv =====
// tfn_pkg: widths, defaults and shared types of the triangle face normal core
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

   localparam int DEF_INDEX_WIDTH = 16;
   localparam int DEF_COORD_WIDTH = 20;

   // coordinates wider than this have their edges pre-shifted down
   localparam int MAX_EDGE_BITS = 30;
   // cross product magnitudes are scaled to below 2^UNIT_W
   localparam int UNIT_W = 30;
   localparam int SQ_W   = 2 * UNIT_W;
   localparam int SUM_W  = SQ_W + 2;
   // u^2 * 2^30 / S never exceeds 2^30
   localparam int QUO_W  = UNIT_W + 1;
   localparam int ROOT_W = (QUO_W + 1) / 2;
   localparam int NORM_W = 16;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } tfn_flags_type;

   function automatic int edge_width(int cw);
      return (cw > MAX_EDGE_BITS) ? MAX_EDGE_BITS + 1 : cw + 1;
   endfunction

   function automatic int cross_width(int cw);
      return 2 * edge_width(cw) + 1;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tfn_if.sv =====
// tfn_req_if, tfn_rsp_if: valid/ready channels of the triangle face normal core
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tfn_req_if
   import tfn_pkg::*;
#(
   parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic        [INDEX_WIDTH-1:0] first_index;
   logic        [INDEX_WIDTH-1:0] second_index;
   logic        [INDEX_WIDTH-1:0] third_index;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] a_z;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] b_z;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] c_z;

   modport source (
      output valid, first_index, second_index, third_index,
             a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
      input  ready
   );
   modport sink (
      input  valid, first_index, second_index, third_index,
             a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
      output ready
   );
endinterface

interface tfn_rsp_if
   import tfn_pkg::*;
#(
   parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
);
   logic                     valid;
   logic                     ready;
   logic signed [NORM_W-1:0] normal_x;
   logic signed [NORM_W-1:0] normal_y;
   logic signed [NORM_W-1:0] normal_z;
   logic                     degenerate;
   logic [INDEX_WIDTH-1:0]   out_first_index;
   logic [INDEX_WIDTH-1:0]   out_second_index;
   logic [INDEX_WIDTH-1:0]   out_third_index;

   modport source (
      output valid, normal_x, normal_y, normal_z, degenerate,
             out_first_index, out_second_index, out_third_index,
      input  ready
   );
   modport sink (
      input  valid, normal_x, normal_y, normal_z, degenerate,
             out_first_index, out_second_index, out_third_index,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/triangle_face_normal_core.sv =====
// Triangle face normal core: one triangle per cycle in, one unit normal per cycle out
// while the output is not held. An accepted req beat passes through the cross product,
// magnitude scaling and squares, the restoring divider that forms u^2 * 2^30 / S, the
// square root, and rounding and sign into the output register that drives rsp_bus.
// The pipeline moves as one; it holds only while a result sits in
// the output register and rsp_bus.ready is low, and otherwise takes a beat every
// cycle. A zero cross product gives a zero normal with degenerate set; indices pass
// through unchanged. Depends on tfn_pkg, tfn_if, tfn_cross, tfn_scale, tfn_div, tfn_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal_core
   import tfn_pkg::*;
#(
   parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   tfn_req_if.sink   req_bus,
   tfn_rsp_if.source rsp_bus
);

   localparam int CROSS_W  = cross_width(COORD_WIDTH);
   localparam int META_LEN = 3 + 5 + QUO_W + ROOT_W;
   localparam int TAIL_LEN = QUO_W + ROOT_W;

   typedef struct packed {
      logic                   valid;
      logic [INDEX_WIDTH-1:0] i0;
      logic [INDEX_WIDTH-1:0] i1;
      logic [INDEX_WIDTH-1:0] i2;
   } tfn_meta_type;

   logic                        en;
   logic signed [COORD_WIDTH-1:0] pos_a [3];
   logic signed [COORD_WIDTH-1:0] pos_b [3];
   logic signed [COORD_WIDTH-1:0] pos_c [3];
   logic signed [CROSS_W-1:0]   xprod [3];
   logic [SQ_W-1:0]             sq [3];
   logic [SUM_W-1:0]            sum_sq;
   tfn_flags_type               flags;
   logic [QUO_W-1:0]            quo [3];
   logic [ROOT_W-1:0]           root [3];
   tfn_meta_type                meta_ff [META_LEN];
   tfn_flags_type               tail_ff [TAIL_LEN];
   logic [NORM_W-1:0]           mag [3];
   logic signed [NORM_W-1:0]    norm_in [3];
   logic signed [NORM_W-1:0]    norm_ff [3];
   logic                        rsp_valid_ff;
   logic                        degen_ff;
   logic [INDEX_WIDTH-1:0]      i0_ff;
   logic [INDEX_WIDTH-1:0]      i1_ff;
   logic [INDEX_WIDTH-1:0]      i2_ff;

   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   always_comb begin
      pos_a = '{req_bus.a_x, req_bus.a_y, req_bus.a_z};
      pos_b = '{req_bus.b_x, req_bus.b_y, req_bus.b_z};
      pos_c = '{req_bus.c_x, req_bus.c_y, req_bus.c_z};
   end

   tfn_cross #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_cross (
      .clock (clock),
      .en    (en),
      .pos_a (pos_a),
      .pos_b (pos_b),
      .pos_c (pos_c),
      .xprod (xprod)
   );

   tfn_scale #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_scale (
      .clock  (clock),
      .en     (en),
      .xprod  (xprod),
      .sq     (sq),
      .sum_sq (sum_sq),
      .flags  (flags)
   );

   for (genvar i = 0; i < 3; i++) begin : g_lane
      tfn_div u_div (
         .clock (clock),
         .en    (en),
         .num   (sq[i]),
         .den   (sum_sq),
         .quo   (quo[i])
      );

      tfn_sqrt u_sqrt (
         .clock (clock),
         .en    (en),
         .rad   (quo[i]),
         .root  (root[i])
      );
   end

   // indices and valid travel alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < META_LEN; i++) begin
            meta_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         meta_ff[0] <= '{req_bus.valid, req_bus.first_index, req_bus.second_index,
                         req_bus.third_index};
         for (int i = 1; i < META_LEN; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tail_ff[0] <= flags;
         for (int i = 1; i < TAIL_LEN; i++) begin
            tail_ff[i] <= tail_ff[i-1];
         end
      end
   end

   // round half up on the root: q = (r + 1) / 2
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = NORM_W'(((ROOT_W + 1)'(root[i]) + (ROOT_W + 1)'(1)) >> 1);
         if (tail_ff[TAIL_LEN-1].degen) begin
            norm_in[i] = '0;
         end else if (tail_ff[TAIL_LEN-1].neg[i]) begin
            norm_in[i] = -signed'(mag[i]);
         end else begin
            norm_in[i] = signed'(mag[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= meta_ff[META_LEN-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff  <= norm_in;
         degen_ff <= tail_ff[TAIL_LEN-1].degen;
         i0_ff    <= meta_ff[META_LEN-1].i0;
         i1_ff    <= meta_ff[META_LEN-1].i1;
         i2_ff    <= meta_ff[META_LEN-1].i2;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.normal_x         = norm_ff[0];
   assign rsp_bus.normal_y         = norm_ff[1];
   assign rsp_bus.normal_z         = norm_ff[2];
   assign rsp_bus.degenerate       = degen_ff;
   assign rsp_bus.out_first_index  = i0_ff;
   assign rsp_bus.out_second_index = i1_ff;
   assign rsp_bus.out_third_index  = i2_ff;

   a_reset_empty : assert property (@(posedge clock) $past(reset) |-> !rsp_bus.valid)
      else $error("result beat present straight after reset");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid && !rsp_bus.ready)
      else $error("input held off without a blocked result");

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.degenerate |->
         rsp_bus.normal_x == 0 && rsp_bus.normal_y == 0 && rsp_bus.normal_z == 0)
      else $error("degenerate triangle with non-zero normal");

   a_live_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.degenerate |->
         rsp_bus.normal_x != 0 || rsp_bus.normal_y != 0 || rsp_bus.normal_z != 0)
      else $error("non-degenerate triangle with zero normal");

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_cross.sv =====
// tfn_cross: edge vectors and cross product, three register stages
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfn_cross
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   localparam int PRE_SHIFT = (COORD_WIDTH > MAX_EDGE_BITS) ? COORD_WIDTH - MAX_EDGE_BITS : 0,
   localparam int EDGE_W = edge_width(COORD_WIDTH),
   localparam int CROSS_W = cross_width(COORD_WIDTH)
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] pos_a [3],
   input  logic signed [COORD_WIDTH-1:0] pos_b [3],
   input  logic signed [COORD_WIDTH-1:0] pos_c [3],
   output logic signed [CROSS_W-1:0]     xprod [3]
);

   logic signed [COORD_WIDTH:0]   d1 [3];
   logic signed [COORD_WIDTH:0]   d2 [3];
   logic signed [EDGE_W-1:0]      e1_in [3];
   logic signed [EDGE_W-1:0]      e2_in [3];
   logic signed [EDGE_W-1:0]      e1_ff [3];
   logic signed [EDGE_W-1:0]      e2_ff [3];
   logic signed [2*EDGE_W-1:0]    prod_in [6];
   logic signed [2*EDGE_W-1:0]    prod_ff [6];
   logic signed [CROSS_W-1:0]     xprod_in [3];
   logic signed [CROSS_W-1:0]     xprod_ff [3];

   // edges from the first corner, floor shifted when coordinates are wide
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1[i]    = pos_b[i] - pos_a[i];
         d2[i]    = pos_c[i] - pos_a[i];
         e1_in[i] = EDGE_W'(d1[i] >>> PRE_SHIFT);
         e2_in[i] = EDGE_W'(d2[i] >>> PRE_SHIFT);
      end
   end

   always_comb begin
      prod_in[0] = e1_ff[1] * e2_ff[2];
      prod_in[1] = e1_ff[2] * e2_ff[1];
      prod_in[2] = e1_ff[2] * e2_ff[0];
      prod_in[3] = e1_ff[0] * e2_ff[2];
      prod_in[4] = e1_ff[0] * e2_ff[1];
      prod_in[5] = e1_ff[1] * e2_ff[0];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xprod_in[i] = prod_ff[2*i] - prod_ff[2*i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
         prod_ff  <= prod_in;
         xprod_ff <= xprod_in;
      end
   end

   assign xprod = xprod_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_scale.sv =====
// tfn_scale: magnitudes, range reduction below 2^30, squares and their sum
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfn_scale
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   localparam int CROSS_W = cross_width(COORD_WIDTH),
   localparam int MAG_W = CROSS_W - 1,
   localparam int K_W = $clog2(MAG_W + 1)
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [CROSS_W-1:0] xprod [3],
   output logic [SQ_W-1:0]           sq [3],
   output logic [SUM_W-1:0]          sum_sq,
   output tfn_flags_type             flags
);

   logic [MAG_W-1:0]  mag_in [3];
   logic [MAG_W-1:0]  mag_ff [3];
   logic [MAG_W-1:0]  mag2_ff [3];
   logic [MAG_W-1:0]  orv_in;
   logic [MAG_W-1:0]  orv_ff;
   logic [2:0]        neg_ff;
   logic [K_W-1:0]    k_in;
   logic [K_W-1:0]    k_ff;
   logic [UNIT_W-1:0] u_in [3];
   logic [UNIT_W-1:0] u_ff [3];
   logic [SQ_W-1:0]   sq_in [3];
   logic [SQ_W-1:0]   sq_ff [3];
   logic [SQ_W-1:0]   sq5_ff [3];
   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  sum_ff;
   tfn_flags_type     f2_ff;
   tfn_flags_type     f3_ff;
   tfn_flags_type     f4_ff;
   tfn_flags_type     f5_ff;

   always_comb begin
      orv_in = '0;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = MAG_W'((xprod[i] < 0) ? -xprod[i] : xprod[i]);
         orv_in    = orv_in | mag_in[i];
      end
   end

   // leading one of the or of magnitudes gives the shift of the largest
   always_comb begin
      k_in = '0;
      for (int i = UNIT_W; i < MAG_W; i++) begin
         if (orv_ff[i]) begin
            k_in = K_W'(i - UNIT_W + 1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i]  = UNIT_W'(mag2_ff[i] >> k_ff);
         sq_in[i] = SQ_W'(u_ff[i]) * SQ_W'(u_ff[i]);
      end
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= xprod[i] < 0;
         end
         mag_ff      <= mag_in;
         orv_ff      <= orv_in;
         k_ff        <= k_in;
         mag2_ff     <= mag_ff;
         f2_ff.neg   <= neg_ff;
         f2_ff.degen <= orv_ff == '0;
         u_ff        <= u_in;
         f3_ff       <= f2_ff;
         sq_ff       <= sq_in;
         f4_ff       <= f3_ff;
         sq5_ff      <= sq_ff;
         sum_ff      <= sum_in;
         f5_ff       <= f4_ff;
      end
   end

   assign sq     = sq5_ff;
   assign sum_sq = sum_ff;
   assign flags  = f5_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_div.sv =====
// tfn_div: restoring divider, one quotient bit per stage, floor(n * 2^30 / d)
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfn_div
   import tfn_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   num,
   input  logic [SUM_W-1:0]  den,
   output logic [QUO_W-1:0]  quo
);

   logic [SUM_W-1:0] rem_ff [QUO_W];
   logic [SUM_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [SUM_W-1:0] rem_prev;
      logic [SUM_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic             bit_in;
      logic [SUM_W:0]   trial;
      logic             ge;

      if (j == 0) begin : g_first
         // dividend is num shifted up by QUO_W-1; all of num enters the first trial here
         assign rem_prev = SUM_W'(num >> 1);
         assign den_prev = den;
         assign quo_prev = '0;
         assign bit_in   = num[0];
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign bit_in   = 1'b0;
      end

      always_comb begin
         trial = {rem_prev, bit_in};
         ge    = trial >= {1'b0, den_prev};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? SUM_W'(trial - {1'b0, den_prev}) : SUM_W'(trial);
            den_ff[j] <= den_prev;
            quo_ff[j] <= {quo_prev[QUO_W-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_sqrt.sv =====
// tfn_sqrt: integer square root, one root bit per stage by remainder update
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfn_sqrt
   import tfn_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [QUO_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   localparam int TRIAL_W = 2 * ROOT_W + 1;

   logic [QUO_W-1:0]  rem_ff [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam int B = ROOT_W - 1 - j;
      logic [QUO_W-1:0]   rem_prev;
      logic [ROOT_W-1:0]  root_prev;
      logic [TRIAL_W-1:0] trial;
      logic               ge;

      if (j == 0) begin : g_first
         assign rem_prev  = rad;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
      always_comb begin
         trial = (TRIAL_W'(root_prev) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
         ge    = TRIAL_W'(rem_prev) >= trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= ge ? QUO_W'(TRIAL_W'(rem_prev) - trial) : rem_prev;
            root_ff[j] <= ge ? (root_prev | (ROOT_W'(1) << B)) : root_prev;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

`default_nettype wire
